// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is high.
`define PRGC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define PRGC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/prgc_pkg.sv -----
// ----------------------------------------------------------------------------
// prgc_pkg
// Types, register indexes and helpers of the primary ray generator.
// ----------------------------------------------------------------------------
package prgc_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int FOV_W      = 31;
   localparam int WORD_W     = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_SIZE = 3'd0,
      REG_FOV_SCALE  = 3'd1,
      REG_MATRIX_A   = 3'd2,
      REG_MATRIX_B   = 3'd3,
      REG_MATRIX_C   = 3'd4,
      REG_MATRIX_D   = 3'd5,
      REG_MATRIX_E   = 3'd6,
      REG_MATRIX_F   = 3'd7
   } csr_index_type;

   typedef logic [2:0][2:0][WORD_W-1:0] mat_type;

   // camera-space direction, signed Q.28
   typedef struct packed {
      logic                   valid;
      logic [2:0][WORD_W-1:0] c;
   } cam_beat_type;

   // world vector, block normalized into [2^30, 2^31)
   typedef struct packed {
      logic             valid;
      logic             zero;
      logic [2:0]       neg;
      logic [2:0][30:0] mag;
   } vec_beat_type;

   typedef struct packed {
      vec_beat_type      vec;
      logic [WORD_W-1:0] len;
   } root_beat_type;

   typedef struct packed {
      logic                   valid;
      logic [2:0][WORD_W-1:0] dir;
   } dir_beat_type;

   // position of the highest set bit plus one, zero for zero
   function automatic logic [6:0] bit_len64(input logic [63:0] v);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) n = 7'(i + 1);
      end
      return n;
   endfunction

endpackage

// ----- design/prgc_if.sv -----
// ----------------------------------------------------------------------------
// prgc_req_if / prgc_rsp_if
// Valid/ready channels for pixel requests and ray responses.
// ----------------------------------------------------------------------------
interface prgc_req_if #(parameter int COORD_BITS = 12) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   modport source (output valid, pixel_x, pixel_y, input ready);
   modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface prgc_rsp_if ();
   logic               valid;
   logic               ready;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [31:0] dir_x;
   logic signed [31:0] dir_y;
   logic signed [31:0] dir_z;
   modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                   output ready);
endinterface

// ----- design/prgc_div.sv -----
// ----------------------------------------------------------------------------
// prgc_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module prgc_div #(
   parameter int LANES  = 2,
   parameter int NUM_W  = 46,
   parameter int DEN_W  = 13,
   parameter int QUO_W  = 45,
   parameter int SIDE_W = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0]            in_den,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   output logic [LANES-1:0][QUO_W-1:0] out_quo,
   output logic [SIDE_W-1:0]           out_side
);
   localparam int ACC_W = DEN_W + QUO_W;

   // upper DEN_W bits: partial remainder; lower: numerator bits, then quotient
   logic                        vld_ff  [0:QUO_W];
   logic [LANES-1:0][ACC_W-1:0] acc_ff  [0:QUO_W];
   logic [DEN_W-1:0]            den_ff  [0:QUO_W];
   logic [SIDE_W-1:0]           side_ff [0:QUO_W];
   logic [LANES-1:0][ACC_W-1:0] acc_in  [1:QUO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
      if (adv) begin
         for (int l = 0; l < LANES; l++) begin
            acc_ff[0][l] <= {DEN_W'(in_num[l][NUM_W-1:QUO_W]), in_num[l][QUO_W-1:0]};
         end
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
   end

   for (genvar s = 1; s <= QUO_W; s++) begin : g_step
      always_comb begin
         logic [DEN_W:0] trial;
         logic           ge;
         for (int l = 0; l < LANES; l++) begin
            trial = {acc_ff[s-1][l][ACC_W-1:QUO_W], acc_ff[s-1][l][QUO_W-1]};
            ge    = trial >= {1'b0, den_ff[s-1]};
            acc_in[s][l] = {ge ? DEN_W'(trial - {1'b0, den_ff[s-1]}) : trial[DEN_W-1:0],
                            acc_ff[s-1][l][QUO_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_ff[s-1];
         end
         if (adv) begin
            acc_ff[s]  <= acc_in[s];
            den_ff[s]  <= den_ff[s-1];
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_quo[l] = acc_ff[QUO_W][l][QUO_W-1:0];
      end
   end
   assign out_valid = vld_ff[QUO_W];
   assign out_side  = side_ff[QUO_W];

endmodule

// ----- design/prgc_cam.sv -----
// ----------------------------------------------------------------------------
// prgc_cam
// Pixel to camera-space direction: screen offset, fov scale, divide by height.
// ----------------------------------------------------------------------------
module prgc_cam #(
   parameter int COORD_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [COORD_BITS-1:0]     pixel_x,
   input  logic [COORD_BITS-1:0]     pixel_y,
   input  logic [2*COORD_BITS-1:0]   image_size,
   input  logic [prgc_pkg::FOV_W-1:0] fov_scale,
   output prgc_pkg::cam_beat_type    out
);
   import prgc_pkg::*;

   localparam int MAG_W  = COORD_BITS + 1;
   localparam int N_W    = COORD_BITS + 3;
   localparam int PROD_W = MAG_W + FOV_W;
   localparam int QUO_W  = PROD_W + 1;
   localparam int DEN_W  = COORD_BITS + 1;

   logic [DEN_W-1:0] width_v, height_v;
   logic signed [N_W-1:0] nx, ny;

   logic             a_vld_ff;
   logic [MAG_W-1:0] a_mx_ff, a_my_ff;
   logic [1:0]       a_neg_ff;
   logic              b_vld_ff;
   logic [PROD_W-1:0] b_px_ff, b_py_ff;
   logic [1:0]        b_neg_ff;
   logic             c_vld_ff;
   logic [1:0][QUO_W:0] c_num_ff;
   logic [1:0]       c_neg_ff;

   logic             q_vld;
   logic [1:0][QUO_W-1:0] q_quo;
   logic [1:0]       q_neg;

   logic             d_vld_ff;
   logic [1:0][QUO_W-1:0] d_q_ff;
   logic [1:0][6:0]  d_len_ff;
   logic [1:0]       d_neg_ff;

   cam_beat_type     out_in, out_ff;

   assign width_v  = {1'b0, image_size[COORD_BITS-1:0]} + DEN_W'(1);
   assign height_v = {1'b0, image_size[2*COORD_BITS-1:COORD_BITS]} + DEN_W'(1);
   assign nx = $signed({2'b00, pixel_x, 1'b1}) - $signed({2'b00, width_v});
   assign ny = $signed({2'b00, height_v}) - $signed({2'b00, pixel_y, 1'b1});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= q_vld;
         out_ff.valid <= d_vld_ff;
      end
      if (adv) begin
         // screen offsets as sign and magnitude
         a_mx_ff  <= nx[N_W-1] ? MAG_W'(-nx) : MAG_W'(nx);
         a_my_ff  <= ny[N_W-1] ? MAG_W'(-ny) : MAG_W'(ny);
         a_neg_ff <= {nx[N_W-1], ny[N_W-1]};
         b_px_ff  <= PROD_W'(a_mx_ff) * PROD_W'(fov_scale);
         b_py_ff  <= PROD_W'(a_my_ff) * PROD_W'(fov_scale);
         b_neg_ff <= a_neg_ff;
         // add half the divisor to round to nearest
         c_num_ff[0] <= (QUO_W+1)'(b_px_ff) + (QUO_W+1)'(height_v >> 1);
         c_num_ff[1] <= (QUO_W+1)'(b_py_ff) + (QUO_W+1)'(height_v >> 1);
         c_neg_ff    <= b_neg_ff;
         d_q_ff      <= q_quo;
         d_len_ff[0] <= bit_len64(64'(q_quo[0]));
         d_len_ff[1] <= bit_len64(64'(q_quo[1]));
         d_neg_ff    <= q_neg;
         out_ff.c    <= out_in.c;
      end
   end

   prgc_div #(
      .LANES  (2),
      .NUM_W  (QUO_W + 1),
      .DEN_W  (DEN_W),
      .QUO_W  (QUO_W),
      .SIDE_W (2)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (c_vld_ff),
      .in_num   (c_num_ff),
      .in_den   (height_v),
      .in_side  (c_neg_ff),
      .out_valid(q_vld),
      .out_quo  (q_quo),
      .out_side (q_neg)
   );

   // block shift: drop low bits of all three until the largest is below 2^30
   always_comb begin
      logic [6:0]  lm, sh;
      logic [29:0] mx, my, mz;
      lm = (d_len_ff[0] > d_len_ff[1]) ? d_len_ff[0] : d_len_ff[1];
      sh = (lm > 7'd30) ? lm - 7'd30 : 7'd0;
      mx = 30'(d_q_ff[0] >> sh);
      my = 30'(d_q_ff[1] >> sh);
      mz = 30'((30'd1 << 28) >> sh);
      out_in.valid = d_vld_ff;
      out_in.c[0]  = d_neg_ff[1] ? -{2'b00, mx} : {2'b00, mx};
      out_in.c[1]  = d_neg_ff[0] ? -{2'b00, my} : {2'b00, my};
      out_in.c[2]  = -{2'b00, mz};
   end

   assign out = out_ff;

endmodule

// ----- design/prgc_xform.sv -----
// ----------------------------------------------------------------------------
// prgc_xform
// Rotate the camera direction into world space and block normalize it.
// ----------------------------------------------------------------------------
module prgc_xform (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  prgc_pkg::cam_beat_type in,
   input  prgc_pkg::mat_type      mat,
   output prgc_pkg::vec_beat_type out
);
   import prgc_pkg::*;

   logic                   p_vld_ff;
   logic [2:0][2:0][63:0]  p_ff;
   logic                   s_vld_ff;
   logic [2:0][63:0]       s_ff;
   logic                   m_vld_ff;
   logic [2:0][62:0]       m_ff;
   logic [2:0]             m_neg_ff;
   logic                   l_vld_ff;
   logic [2:0][62:0]       l_mag_ff;
   logic [2:0][6:0]        l_len_ff;
   logic [2:0]             l_neg_ff;
   vec_beat_type           out_in, out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
         m_vld_ff <= 1'b0;
         l_vld_ff <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         p_vld_ff <= in.valid;
         s_vld_ff <= p_vld_ff;
         m_vld_ff <= s_vld_ff;
         l_vld_ff <= m_vld_ff;
         out_ff.valid <= l_vld_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p_ff[i][j] <= 64'($signed(mat[i][j]) * $signed(in.c[j]));
            end
            s_ff[i]     <= p_ff[i][0] + p_ff[i][1] + p_ff[i][2];
            m_ff[i]     <= s_ff[i][63] ? 63'(-s_ff[i]) : s_ff[i][62:0];
            m_neg_ff[i] <= s_ff[i][63];
            l_mag_ff[i] <= m_ff[i];
            l_len_ff[i] <= bit_len64({1'b0, m_ff[i]});
         end
         l_neg_ff   <= m_neg_ff;
         out_ff.zero <= out_in.zero;
         out_ff.neg  <= out_in.neg;
         out_ff.mag  <= out_in.mag;
      end
   end

   // shift all three so the largest lands in [2^30, 2^31)
   always_comb begin
      logic [6:0] lm;
      lm = l_len_ff[0];
      if (l_len_ff[1] > lm) lm = l_len_ff[1];
      if (l_len_ff[2] > lm) lm = l_len_ff[2];
      out_in.valid = l_vld_ff;
      out_in.zero  = (lm == 7'd0);
      out_in.neg   = l_neg_ff;
      for (int i = 0; i < 3; i++) begin
         out_in.mag[i] = (lm > 7'd31) ? 31'(l_mag_ff[i] >> (lm - 7'd31))
                                      : 31'(l_mag_ff[i] << (7'd31 - lm));
      end
   end

   assign out = out_ff;

endmodule

// ----- design/prgc_isqrt.sv -----
// ----------------------------------------------------------------------------
// prgc_isqrt
// Vector length: sum of squares, then one root digit per stage.
// ----------------------------------------------------------------------------
module prgc_isqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  prgc_pkg::vec_beat_type  in,
   output prgc_pkg::root_beat_type out
);
   import prgc_pkg::*;

   localparam int STEPS = 32;

   vec_beat_type       q_vec_ff;
   logic [2:0][61:0]   q_sq_ff;
   vec_beat_type       vec_ff [0:STEPS];
   logic [63:0]        v_ff   [0:STEPS];
   logic [63:0]        r_ff   [0:STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vec_ff.valid  <= 1'b0;
         vec_ff[0].valid <= 1'b0;
      end else if (adv) begin
         q_vec_ff.valid  <= in.valid;
         vec_ff[0].valid <= q_vec_ff.valid;
      end
      if (adv) begin
         q_vec_ff.zero <= in.zero;
         q_vec_ff.neg  <= in.neg;
         q_vec_ff.mag  <= in.mag;
         for (int i = 0; i < 3; i++) begin
            q_sq_ff[i] <= 62'(in.mag[i]) * 62'(in.mag[i]);
         end
         vec_ff[0].zero <= q_vec_ff.zero;
         vec_ff[0].neg  <= q_vec_ff.neg;
         vec_ff[0].mag  <= q_vec_ff.mag;
         v_ff[0] <= 64'(q_sq_ff[0]) + 64'(q_sq_ff[1]) + 64'(q_sq_ff[2]);
         r_ff[0] <= '0;
      end
   end

   for (genvar t = 1; t <= STEPS; t++) begin : g_root
      localparam logic [63:0] BIT = 64'd1 << (64 - 2 * t);
      logic        ge;
      logic [63:0] rb;
      assign rb = r_ff[t-1] + BIT;
      assign ge = v_ff[t-1] >= rb;

      always_ff @(posedge clock) begin
         if (reset) begin
            vec_ff[t].valid <= 1'b0;
         end else if (adv) begin
            vec_ff[t].valid <= vec_ff[t-1].valid;
         end
         if (adv) begin
            vec_ff[t].zero <= vec_ff[t-1].zero;
            vec_ff[t].neg  <= vec_ff[t-1].neg;
            vec_ff[t].mag  <= vec_ff[t-1].mag;
            v_ff[t] <= ge ? v_ff[t-1] - rb : v_ff[t-1];
            r_ff[t] <= ge ? (r_ff[t-1] >> 1) + BIT : r_ff[t-1] >> 1;
         end
      end
   end

   assign out.vec = vec_ff[STEPS];
   assign out.len = r_ff[STEPS][31:0];

endmodule

// ----- design/prgc_norm.sv -----
// ----------------------------------------------------------------------------
// prgc_norm
// Divide each component by the length, round to nearest, restore signs.
// ----------------------------------------------------------------------------
module prgc_norm (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  prgc_pkg::root_beat_type in,
   output prgc_pkg::dir_beat_type  out
);
   import prgc_pkg::*;

   logic             n_vld_ff;
   logic [2:0][61:0] n_num_ff;
   logic [31:0]      n_len_ff;
   logic [3:0]       n_side_ff;
   logic             q_vld;
   logic [2:0][30:0] q_quo;
   logic [3:0]       q_side;
   dir_beat_type     out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_vld_ff     <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         n_vld_ff     <= in.vec.valid;
         out_ff.valid <= q_vld;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            n_num_ff[i] <= 62'({in.vec.mag[i], 30'd0}) + 62'(in.len[31:1]);
            // zero vector gives zero direction; otherwise apply the sign
            out_ff.dir[i] <= q_side[3] ? 32'd0 :
                             q_side[i] ? -{1'b0, q_quo[i]} : {1'b0, q_quo[i]};
         end
         n_len_ff  <= in.len;
         n_side_ff <= {in.vec.zero, in.vec.neg};
      end
   end

   prgc_div #(
      .LANES  (3),
      .NUM_W  (62),
      .DEN_W  (32),
      .QUO_W  (31),
      .SIDE_W (4)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (n_vld_ff),
      .in_num   (n_num_ff),
      .in_den   (n_len_ff),
      .in_side  (n_side_ff),
      .out_valid(q_vld),
      .out_quo  (q_quo),
      .out_side (q_side)
   );

   assign out = out_ff;

endmodule

// ----- design/primary_ray_generator_core.sv -----
// Pipeline: two bit-serial divider pipelines and the 32-stage square-root
//   pipeline lie between an accepted request beat and its response beat.
// Throughput: one pixel per cycle, held on a response stall with a full buffer.
// Reset: synchronous, active high; clears all valid bits, the output buffer and
//   loads the registers with an identity camera of 1.0 fov and a 1x1 image.
// ----------------------------------------------------------------------------
// primary_ray_generator_core
// Pinhole camera primary ray generator: pixel coordinates in, world-space ray
// origin and unit direction out.
// ----------------------------------------------------------------------------
module primary_ray_generator_core #(
   parameter int PIXEL_COORD_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   prgc_req_if.sink                         req_chan,
   prgc_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [prgc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [prgc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import prgc_pkg::*;

   // configuration registers
   logic [2*PIXEL_COORD_BITS-1:0] image_size_ff;
   logic [FOV_W-1:0]              fov_scale_ff;
   logic [5:0][CSR_DATA_W-1:0]    matrix_ff;
   mat_type                       mat;

   logic          adv;
   cam_beat_type  cam;
   vec_beat_type  vec;
   root_beat_type root;
   dir_beat_type  fin;

   // two-entry output buffer; entry 0 drives the response
   logic [1:0]             cnt_ff;
   logic [2:0][WORD_W-1:0] ent0_ff, ent1_ff;
   logic                   push, pop;
   logic                   fill0;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_size_ff <= '0;
         fov_scale_ff  <= FOV_W'(1) << 28;
         matrix_ff[0]  <= CSR_DATA_W'(1) << 30;
         matrix_ff[1]  <= '0;
         matrix_ff[2]  <= CSR_DATA_W'(1) << 30;
         matrix_ff[3]  <= '0;
         matrix_ff[4]  <= CSR_DATA_W'(1) << 30;
         matrix_ff[5]  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_IMAGE_SIZE: image_size_ff <= csr_wdata[2*PIXEL_COORD_BITS-1:0];
            REG_FOV_SCALE:  fov_scale_ff  <= csr_wdata[FOV_W-1:0];
            REG_MATRIX_A:   matrix_ff[0]  <= csr_wdata;
            REG_MATRIX_B:   matrix_ff[1]  <= csr_wdata;
            REG_MATRIX_C:   matrix_ff[2]  <= csr_wdata;
            REG_MATRIX_D:   matrix_ff[3]  <= csr_wdata;
            REG_MATRIX_E:   matrix_ff[4]  <= csr_wdata;
            REG_MATRIX_F:   matrix_ff[5]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // unpack the rotation; row i, column j
   assign mat[0][0] = matrix_ff[0][31:0];
   assign mat[0][1] = matrix_ff[0][63:32];
   assign mat[0][2] = matrix_ff[1][31:0];
   assign mat[1][0] = matrix_ff[1][63:32];
   assign mat[1][1] = matrix_ff[2][31:0];
   assign mat[1][2] = matrix_ff[2][63:32];
   assign mat[2][0] = matrix_ff[3][31:0];
   assign mat[2][1] = matrix_ff[3][63:32];
   assign mat[2][2] = matrix_ff[4][31:0];

   // advance the pipeline unless the output buffer is full and not draining
   assign adv            = (cnt_ff != 2'd2) || rsp_chan.ready;
   assign req_chan.ready = adv;

   prgc_cam #(.COORD_BITS(PIXEL_COORD_BITS)) u_cam (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_chan.valid),
      .pixel_x   (req_chan.pixel_x),
      .pixel_y   (req_chan.pixel_y),
      .image_size(image_size_ff),
      .fov_scale (fov_scale_ff),
      .out       (cam)
   );

   prgc_xform u_xform (
      .clock(clock),
      .reset(reset),
      .adv  (adv),
      .in   (cam),
      .mat  (mat),
      .out  (vec)
   );

   prgc_isqrt u_isqrt (
      .clock(clock),
      .reset(reset),
      .adv  (adv),
      .in   (vec),
      .out  (root)
   );

   prgc_norm u_norm (
      .clock(clock),
      .reset(reset),
      .adv  (adv),
      .in   (root),
      .out  (fin)
   );

   assign push  = adv && fin.valid;
   assign pop   = (cnt_ff != 2'd0) && rsp_chan.ready;
   // the new beat lands in entry 0 when that slot is free after this edge
   assign fill0 = push && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= 2'(cnt_ff + 2'(push) - 2'(pop));
      end
      // hold entries; shift down on pop, fill the first free slot on push
      if (fill0) begin
         ent0_ff <= fin.dir;
      end else if (pop) begin
         ent0_ff <= ent1_ff;
      end
      if (push && !fill0) begin
         ent1_ff <= fin.dir;
      end
   end

   // origin is the translation; user must keep it stable while beats are in flight (not enforced)
   assign rsp_chan.valid    = cnt_ff != 2'd0;
   assign rsp_chan.origin_x = $signed(matrix_ff[4][63:32]);
   assign rsp_chan.origin_y = $signed(matrix_ff[5][31:0]);
   assign rsp_chan.origin_z = $signed(matrix_ff[5][63:32]);
   assign rsp_chan.dir_x    = $signed(ent0_ff[0]);
   assign rsp_chan.dir_y    = $signed(ent0_ff[1]);
   assign rsp_chan.dir_z    = $signed(ent0_ff[2]);

endmodule

// ----- design/prgc_checker.sv -----
// ----------------------------------------------------------------------------
// prgc_checker
// Port-level checks of the ray generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prgc_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] origin_x,
   input logic signed [31:0] dir_x,
   input logic signed [31:0] dir_y,
   input logic signed [31:0] dir_z
);
   localparam logic signed [31:0] DIR_ONE  = 32'sd1073741824;
   localparam logic signed [31:0] DIR_HALF = 32'sd536870912;

   `PRGC_ASSERT_ALWAYS(a_no_beat_after_reset, clock, reset |=> !rsp_valid, "response after reset")

   `PRGC_ASSERT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(dir_x) && $stable(dir_y) && $stable(dir_z) && $stable(origin_x), "stalled beat changed")

   `PRGC_ASSERT(a_dir_range, clock, reset, rsp_valid |-> dir_x <= DIR_ONE && dir_x >= -DIR_ONE && dir_y <= DIR_ONE && dir_y >= -DIR_ONE && dir_z <= DIR_ONE && dir_z >= -DIR_ONE, "direction beyond unit")

   `PRGC_ASSERT(a_dir_unit, clock, reset, rsp_valid |-> (dir_x == 0 && dir_y == 0 && dir_z == 0) || dir_x >= DIR_HALF || dir_x <= -DIR_HALF || dir_y >= DIR_HALF || dir_y <= -DIR_HALF || dir_z >= DIR_HALF || dir_z <= -DIR_HALF, "direction not normalized")

endmodule

bind primary_ray_generator_core prgc_checker u_prgc_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .origin_x (rsp_chan.origin_x),
   .dir_x    (rsp_chan.dir_x),
   .dir_y    (rsp_chan.dir_y),
   .dir_z    (rsp_chan.dir_z)
);
